// File: hw/rtl/clt_pkg.sv
// Shared types, operation codes and constants for the cursor list table.
`timescale 1ns / 1ps

package clt_pkg;

   // Lengths, cursors, positions and the limit register are all 8 bits wide.
   localparam int CountWidth = 8;
   localparam int DataWidth = 32;
   localparam int CapacityDefault = 128;

   typedef logic [CountWidth-1:0] count_type;
   typedef logic [DataWidth-1:0] data_type;
   typedef logic [3:0] kind_type;

   localparam count_type LimitReset = count_type'(128);

   // Operation codes carried by the kind field.
   localparam kind_type KindAppend = 4'd0;
   localparam kind_type KindInsert = 4'd1;
   localparam kind_type KindRemove = 4'd2;
   localparam kind_type KindStart = 4'd3;
   localparam kind_type KindEnd = 4'd4;
   localparam kind_type KindPrev = 4'd5;
   localparam kind_type KindNext = 4'd6;
   localparam kind_type KindSetPos = 4'd7;
   localparam kind_type KindReadCursor = 4'd8;
   localparam kind_type KindReadIndex = 4'd9;
   localparam kind_type KindClear = 4'd10;

   typedef enum logic [1:0] {
      StatusOk = 2'd0,
      StatusFull = 2'd1,
      StatusEmpty = 2'd2,
      StatusBadPos = 2'd3
   } status_type;

   typedef struct packed {
      status_type status;
      data_type value;
      count_type length;
      count_type cursor;
   } result_type;

endpackage

// File: hw/rtl/clt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module clt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/clt_ctrl.sv
// Operation sequencer: decodes each word, keeps length and cursor, and shifts entries.
`timescale 1ns / 1ps

module clt_ctrl #(
   parameter int CAPACITY = clt_pkg::CapacityDefault
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input clt_pkg::kind_type req_kind,
   input clt_pkg::data_type req_item_value,
   input clt_pkg::count_type req_position,
   input clt_pkg::count_type limit,
   output logic result_valid,
   output clt_pkg::result_type result,
   input logic result_take,
   output logic mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
   output clt_pkg::data_type mem_wr_data,
   output logic mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
   input clt_pkg::data_type mem_rd_data
);

   import clt_pkg::*;

   localparam int AddrWidth = $clog2(CAPACITY);
   localparam int CountMax = (1 << CountWidth) - 1;
   localparam count_type LimitCeiling =
      (CAPACITY > CountMax) ? count_type'(CountMax) : count_type'(CAPACITY);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_UP = 5'b00010,
      S_DOWN = 5'b00100,
      S_READ = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   count_type length_ff, length_in;
   count_type cursor_ff, cursor_in;
   count_type idx_ff, idx_in;
   data_type item_ff, item_in;
   data_type value_ff, value_in;
   status_type status_ff, status_in;
   count_type eff_limit;

   assign eff_limit = (limit < LimitCeiling) ? limit : LimitCeiling;

   always_comb begin
      state_in = state_ff;
      length_in = length_ff;
      cursor_in = cursor_ff;
      idx_in = idx_ff;
      item_in = item_ff;
      value_in = value_ff;
      status_in = status_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = item_ff;
      mem_rd_en = 1'b0;
      mem_rd_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_item_value;
               status_in = StatusOk;
               value_in = '0;
               state_in = S_DONE;
               unique case (req_kind)
                  KindAppend: begin
                     if (length_ff >= eff_limit) begin
                        status_in = StatusFull;
                     end else begin
                        mem_wr_en = 1'b1;
                        mem_wr_addr = AddrWidth'(length_ff);
                        mem_wr_data = req_item_value;
                        length_in = length_ff + count_type'(1);
                     end
                  end
                  KindInsert: begin
                     if (length_ff >= eff_limit) begin
                        status_in = StatusFull;
                     end else begin
                        length_in = length_ff + count_type'(1);
                        if (cursor_ff == length_ff) begin
                           mem_wr_en = 1'b1;
                           mem_wr_addr = AddrWidth'(length_ff);
                           mem_wr_data = req_item_value;
                        end else begin
                           // Move entries up from the top, one per cycle.
                           mem_rd_en = 1'b1;
                           mem_rd_addr = AddrWidth'(length_ff - count_type'(1));
                           idx_in = length_ff;
                           state_in = S_UP;
                        end
                     end
                  end
                  KindRemove: begin
                     if (length_ff == '0) begin
                        status_in = StatusEmpty;
                     end else if (cursor_ff >= length_ff) begin
                        status_in = StatusBadPos;
                     end else begin
                        length_in = length_ff - count_type'(1);
                        if (cursor_ff != length_ff - count_type'(1)) begin
                           mem_rd_en = 1'b1;
                           mem_rd_addr = AddrWidth'(cursor_ff + count_type'(1));
                           idx_in = cursor_ff;
                           state_in = S_DOWN;
                        end
                     end
                  end
                  KindStart: begin
                     cursor_in = '0;
                  end
                  KindEnd: begin
                     cursor_in = length_ff;
                  end
                  KindPrev: begin
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_ff - count_type'(1);
                     end
                  end
                  KindNext: begin
                     if (cursor_ff < length_ff) begin
                        cursor_in = cursor_ff + count_type'(1);
                     end
                  end
                  KindSetPos: begin
                     if (req_position <= length_ff) begin
                        cursor_in = req_position;
                     end else begin
                        status_in = StatusBadPos;
                     end
                  end
                  KindReadCursor: begin
                     if (length_ff == '0) begin
                        status_in = StatusEmpty;
                     end else if (cursor_ff >= length_ff) begin
                        status_in = StatusBadPos;
                     end else begin
                        mem_rd_en = 1'b1;
                        mem_rd_addr = AddrWidth'(cursor_ff);
                        state_in = S_READ;
                     end
                  end
                  KindReadIndex: begin
                     if (req_position < length_ff) begin
                        mem_rd_en = 1'b1;
                        mem_rd_addr = AddrWidth'(req_position);
                        state_in = S_READ;
                     end else begin
                        status_in = StatusBadPos;
                     end
                  end
                  KindClear: begin
                     length_in = '0;
                     cursor_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_UP: begin
            // Each cycle writes the entry read in the previous cycle one slot higher;
            // the slot at the cursor finally takes the new value.
            mem_wr_en = 1'b1;
            mem_wr_addr = AddrWidth'(idx_ff);
            if (idx_ff == cursor_ff) begin
               mem_wr_data = item_ff;
               state_in = S_DONE;
            end else begin
               mem_wr_data = mem_rd_data;
               idx_in = idx_ff - count_type'(1);
               if (idx_ff - count_type'(1) != cursor_ff) begin
                  mem_rd_en = 1'b1;
                  mem_rd_addr = AddrWidth'(idx_ff - count_type'(2));
               end
            end
         end
         S_DOWN: begin
            // Length already holds the shortened value, so the last slot
            // to fill is one below it.
            mem_wr_en = 1'b1;
            mem_wr_addr = AddrWidth'(idx_ff);
            mem_wr_data = mem_rd_data;
            if (idx_ff + count_type'(1) == length_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + count_type'(1);
               mem_rd_en = 1'b1;
               mem_rd_addr = AddrWidth'(idx_ff + count_type'(2));
            end
         end
         S_READ: begin
            value_in = mem_rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (result_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         length_ff <= '0;
         cursor_ff <= '0;
      end else begin
         state_ff <= state_in;
         length_ff <= length_in;
         cursor_ff <= cursor_in;
      end
      idx_ff <= idx_in;
      item_ff <= item_in;
      value_ff <= value_in;
      status_ff <= status_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign result_valid = (state_ff == S_DONE);
   assign result.status = status_ff;
   assign result.value = (status_ff != StatusOk) ? '1 : value_ff;
   assign result.length = length_ff;
   assign result.cursor = cursor_ff;

   // The cursor never runs past the end of the list.
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= length_ff)
      else $error("cursor beyond list length");

   // The list never grows past what the memory can hold.
   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LimitCeiling)
      else $error("list length beyond capacity");

   // A shift step never reads the entry it is writing in the same cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("read and write of the same entry in one cycle");

   // While a finished result waits, the memory is left alone.
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (!mem_wr_en && !mem_rd_en))
      else $error("memory access while holding a result");

   // Every shift toward the cursor ends with a result on the following cycle.
   a_up_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP && idx_ff == cursor_ff) |=> (state_ff == S_DONE))
      else $error("insert did not finish after writing the new value");

endmodule

// File: hw/rtl/cursor_list_table_unit.sv
// Top level of the cursor list table: ports, limit register and response register.
`timescale 1ns / 1ps

// The block keeps an ordered list of signed 32-bit entries with a length and a
// cursor. Each request word on the req_ channel carries one operation (append,
// insert or remove at the cursor, cursor moves, reads, clear) and yields exactly
// one response word on the rsp_ channel with a status, the value read, and the
// length and cursor after the operation. Both channels use valid and ready.
// The csr_ channel writes the capacity limit; it is always ready and should
// only be written while no request is in flight.
// Requests are handled one at a time. Moves, clear, appends, errors and an
// insert with the cursor at the end go from acceptance straight to the result;
// reads pass through a read state. An insert that moves entries shifts them up
// from the top and a remove shifts them down from the cursor, each moved entry
// needing one read and one write through the single entry RAM. The response
// word turns valid in the same cycle that req_ready returns.
// The response sits in an output register, so a new request is accepted and
// worked on while an earlier response waits for rsp_ready; only its result
// then waits inside the sequencer until the register frees up.
// Synchronous reset empties the list, moves the cursor to 0 and sets the limit
// to 128. RAM contents are not cleared: entries at or above the length are
// never read.

module cursor_list_table_unit #(
   parameter int CAPACITY = clt_pkg::CapacityDefault
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input clt_pkg::kind_type req_kind,
   input logic signed [clt_pkg::DataWidth-1:0] req_item_value,
   input clt_pkg::count_type req_position,
   output logic rsp_valid,
   input logic rsp_ready,
   output clt_pkg::status_type rsp_status,
   output logic signed [clt_pkg::DataWidth-1:0] rsp_read_value,
   output clt_pkg::count_type rsp_list_length,
   output clt_pkg::count_type rsp_cursor_now,
   input logic csr_valid,
   output logic csr_ready,
   input clt_pkg::count_type csr_capacity_limit
);

   import clt_pkg::*;

   localparam int AddrWidth = $clog2(CAPACITY);

   // Capacity limit register, written whenever a configuration word arrives.
   count_type limit_ff, limit_in;

   // Response register that decouples the sequencer from the receiver.
   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic result_valid;
   logic result_take;
   result_type result;

   logic mem_wr_en;
   logic [AddrWidth-1:0] mem_wr_addr;
   data_type mem_wr_data;
   logic mem_rd_en;
   logic [AddrWidth-1:0] mem_rd_addr;
   data_type mem_rd_data;

   assign csr_ready = 1'b1;
   assign limit_in = (csr_valid && csr_ready) ? csr_capacity_limit : limit_ff;

   // The register can take a new result when it is empty or is being drained.
   assign result_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (result_take) begin
         rsp_valid_in = result_valid;
         if (result_valid) begin
            rsp_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   clt_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_item_value($unsigned(req_item_value)),
      .req_position(req_position),
      .limit(limit_ff),
      .result_valid(result_valid),
      .result(result),
      .result_take(result_take),
      .mem_wr_en(mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_en(mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   clt_ram #(
      .WIDTH(DataWidth),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock(clock),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en(mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_read_value = $signed(rsp_ff.value);
   assign rsp_list_length = rsp_ff.length;
   assign rsp_cursor_now = rsp_ff.cursor;

   // A response held under backpressure keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ff)))
      else $error("response changed while stalled");

   // Errors always report all ones as the read value.
   a_error_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != StatusOk) |-> (rsp_ff.value == '1))
      else $error("error response without all-ones read value");

   // A result is only moved into the register when it is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (result_valid && rsp_valid_ff && !rsp_ready) |=> $stable(rsp_ff))
      else $error("pending response overwritten");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the cursor list table: directed and random operation traffic.
`timescale 1ns / 1ps

module tb;
   import clt_pkg::*;

   // Kinds 11 to 15 carry no operation; the block must leave the list alone.
   localparam kind_type KindReservedLo = 4'd11;
   localparam kind_type KindReservedHi = 4'd15;

   localparam data_type MostNegative = 32'h8000_0000;
   localparam data_type MostPositive = 32'h7fff_ffff;
   localparam data_type AllOnes = 32'hffff_ffff;

   // An insert at the start of a nearly full list moves every entry, and a stalled
   // receiver adds its own wait on top, so a run of WatchdogLimit quiet cycles means a hang.
   localparam int WatchdogLimit = 3000;
   localparam int SettleCycles = 4;
   localparam int TailCycles = 150;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   kind_type req_kind;
   logic signed [DataWidth-1:0] req_item_value;
   count_type req_position;
   logic rsp_valid;
   logic rsp_ready;
   status_type rsp_status;
   logic signed [DataWidth-1:0] rsp_read_value;
   count_type rsp_list_length;
   count_type rsp_cursor_now;
   logic csr_valid;
   logic csr_ready;
   count_type csr_capacity_limit;

   cursor_list_table_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_item_value(req_item_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_read_value(rsp_read_value),
      .rsp_list_length(rsp_list_length),
      .rsp_cursor_now(rsp_cursor_now),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_capacity_limit(csr_capacity_limit)
   );

   // Shadow copy of the list. Only entries below the shadow length are ever
   // read, and each of those has been written by an append or an insert.
   data_type shadow_entries [CapacityDefault];
   int shadow_length;
   int shadow_cursor;
   count_type shadow_limit;
   int peak_length;

   // Responses the block owes us, oldest first.
   result_type due_results[$];
   result_type want;

   int req_gap_pct;
   int rsp_stall_pct;
   int sent_count;
   int checked_count;
   int fail_count;
   int full_seen;
   int empty_seen;
   int badpos_seen;
   int quiet_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one operation to the shadow list and returns the response the
   // block has to give for it.
   function automatic result_type apply_list_op(kind_type k, data_type v, count_type p);
      result_type r;
      int lim;
      int i;
      r.status = StatusOk;
      r.value = '0;
      lim = (int'(shadow_limit) < CapacityDefault) ? int'(shadow_limit) : CapacityDefault;
      case (k)
         KindAppend: begin
            if (shadow_length >= lim) begin
               r.status = StatusFull;
            end else begin
               shadow_entries[shadow_length] = v;
               shadow_length++;
            end
         end
         KindInsert: begin
            if (shadow_length >= lim) begin
               r.status = StatusFull;
            end else begin
               // Later entries move up by one; with the cursor at the end
               // nothing moves and the value lands at the end.
               for (i = shadow_length; i > shadow_cursor; i--) begin
                  shadow_entries[i] = shadow_entries[i-1];
               end
               shadow_entries[shadow_cursor] = v;
               shadow_length++;
            end
         end
         KindRemove: begin
            if (shadow_length == 0) begin
               r.status = StatusEmpty;
            end else if (shadow_cursor >= shadow_length) begin
               r.status = StatusBadPos;
            end else begin
               for (i = shadow_cursor; i + 1 < shadow_length; i++) begin
                  shadow_entries[i] = shadow_entries[i+1];
               end
               shadow_length--;
            end
         end
         KindStart: shadow_cursor = 0;
         KindEnd: shadow_cursor = shadow_length;
         KindPrev: begin
            if (shadow_cursor != 0) begin
               shadow_cursor--;
            end
         end
         KindNext: begin
            if (shadow_cursor < shadow_length) begin
               shadow_cursor++;
            end
         end
         KindSetPos: begin
            if (int'(p) <= shadow_length) begin
               shadow_cursor = int'(p);
            end else begin
               r.status = StatusBadPos;
            end
         end
         KindReadCursor: begin
            if (shadow_length == 0) begin
               r.status = StatusEmpty;
            end else if (shadow_cursor >= shadow_length) begin
               r.status = StatusBadPos;
            end else begin
               r.value = shadow_entries[shadow_cursor];
            end
         end
         KindReadIndex: begin
            if (int'(p) < shadow_length) begin
               r.value = shadow_entries[p];
            end else begin
               r.status = StatusBadPos;
            end
         end
         KindClear: begin
            shadow_length = 0;
            shadow_cursor = 0;
         end
         default: ;
      endcase
      if (r.status != StatusOk) begin
         r.value = AllOnes;
      end
      if (shadow_length > peak_length) begin
         peak_length = shadow_length;
      end
      r.length = count_type'(shadow_length);
      r.cursor = count_type'(shadow_cursor);
      return r;
   endfunction

   // Sends one request word, with a random gap in front of it. Valid stays
   // high after acceptance so that back-to-back words carry no bubble; the
   // caller lowers it through drain_responses before anything else.
   task automatic send_op(kind_type k, data_type v, count_type p);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_kind = k;
      req_item_value = v;
      req_position = p;
      do @(posedge clock); while (!req_ready);
      due_results.push_back(apply_list_op(k, v, p));
      sent_count++;
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (due_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // The limit register may only change while no request is in flight.
   task automatic write_limit(count_type lim);
      drain_responses();
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_capacity_limit = lim;
      do @(posedge clock); while (!csr_ready);
      shadow_limit = lim;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Reads, removes and cursor steps on an empty list, including the error reports for reads
   // and removes, the out-of-range index and position, and a spare kind.
   task automatic test_empty_list();
      send_op(KindReadCursor, $urandom, 8'd0);
      send_op(KindRemove, $urandom, 8'd0);
      send_op(KindReadIndex, $urandom, 8'd255);
      send_op(KindPrev, $urandom, 8'd0);
      send_op(KindNext, $urandom, 8'd0);
      send_op(KindSetPos, $urandom, 8'd1);
      send_op(KindSetPos, $urandom, 8'd0);
      send_op(KindReservedHi, AllOnes, 8'd255);
   endtask

   // Edits at both ends of a short list, with the extreme values stored.
   task automatic test_edits_at_cursor();
      send_op(KindAppend, MostNegative, 8'd0);
      send_op(KindAppend, MostPositive, 8'd0);
      send_op(KindInsert, AllOnes, 8'd0);
      send_op(KindEnd, 32'd0, 8'd0);
      // Insert with the cursor at the end appends and leaves the cursor.
      send_op(KindInsert, 32'd0, 8'd0);
      send_op(KindReadCursor, 32'd0, 8'd0);
      send_op(KindNext, 32'd0, 8'd0);
      // With the cursor past the last entry, read and remove are refused.
      send_op(KindReadCursor, 32'd0, 8'd0);
      send_op(KindRemove, 32'd0, 8'd0);
      send_op(KindSetPos, 32'd0, 8'd128);
      send_op(KindStart, 32'd0, 8'd0);
      send_op(KindReadCursor, 32'd0, 8'd0);
      send_op(KindRemove, 32'd0, 8'd0);
      send_op(KindReadIndex, 32'd0, 8'd0);
      send_op(KindReadIndex, 32'd0, 8'd3);
      send_op(KindPrev, 32'd0, 8'd0);
      send_op(KindClear, 32'd0, 8'd0);
   endtask

   // A zero limit refuses every append and insert; a limit of one takes one.
   task automatic test_limit_extremes();
      write_limit(8'd0);
      send_op(KindAppend, MostPositive, 8'd0);
      send_op(KindInsert, MostNegative, 8'd0);
      write_limit(8'd1);
      send_op(KindAppend, 32'h5a5a_a5a5, 8'd0);
      send_op(KindInsert, 32'ha5a5_5a5a, 8'd0);
   endtask

   // Random operations under one limit setting. add_weight biases the mix
   // toward appends and inserts so that the list grows to its limit.
   task automatic test_random_traffic(int count, count_type lim, int add_weight,
                                      int gap_pct, int stall_pct);
      kind_type k;
      data_type v;
      count_type p;
      int pick;
      int n;
      write_limit(lim);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < add_weight) begin
            k = pick[0] ? KindAppend : KindInsert;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30) k = KindRemove;
            else if (pick < 34) k = KindStart;
            else if (pick < 38) k = KindEnd;
            else if (pick < 45) k = KindPrev;
            else if (pick < 52) k = KindNext;
            else if (pick < 64) k = KindSetPos;
            else if (pick < 76) k = KindReadCursor;
            else if (pick < 90) k = KindReadIndex;
            // A fill phase never clears, or the list would not reach its limit.
            else if (pick < 95) k = (add_weight >= 50) ? KindReadIndex : KindClear;
            else k = kind_type'($urandom_range(KindReservedLo, KindReservedHi));
         end
         case ($urandom_range(0, 15))
            0: v = MostNegative;
            1: v = MostPositive;
            2: v = AllOnes;
            default: v = $urandom;
         endcase
         // Positions mostly land in or just past the list; some span all 8 bits.
         if ($urandom_range(0, 9) == 0) begin
            p = count_type'($urandom_range(0, 255));
         end else begin
            p = count_type'($urandom_range(0, shadow_length + 1));
         end
         send_op(k, v, p);
      end
   endtask

   // The receiver stalls at random at the current rate.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Each response word is compared, field by field, against the oldest
   // outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         case (rsp_status)
            StatusFull: full_seen++;
            StatusEmpty: empty_seen++;
            StatusBadPos: badpos_seen++;
            default: ;
         endcase
         if (due_results.size() == 0) begin
            $display("%0t: response word with nothing outstanding: status %0d value %0d",
                     $time, rsp_status, rsp_read_value);
            fail_count++;
         end else begin
            want = due_results.pop_front();
            checked_count++;
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_read_value !== want.value) begin
               $display("%0t: read value expected %0d, got %0d",
                        $time, $signed(want.value), rsp_read_value);
               fail_count++;
            end
            if (rsp_list_length !== want.length) begin
               $display("%0t: length expected %0d, got %0d", $time, want.length, rsp_list_length);
               fail_count++;
            end
            if (rsp_cursor_now !== want.cursor) begin
               $display("%0t: cursor expected %0d, got %0d", $time, want.cursor, rsp_cursor_now);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                  $time, quiet_cycles, due_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KindAppend;
      req_item_value = '0;
      req_position = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_capacity_limit = LimitReset;
      shadow_length = 0;
      shadow_cursor = 0;
      shadow_limit = LimitReset;
      peak_length = 0;
      req_gap_pct = 10;
      rsp_stall_pct = 84;
      sent_count = 0;
      checked_count = 0;
      fail_count = 0;
      full_seen = 0;
      empty_seen = 0;
      badpos_seen = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      test_edits_at_cursor();
      test_limit_extremes();

      // First the receiver stalls most of the time, then the sender gaps,
      // then words flow with no idling at all.
      test_random_traffic(330, 8'd255, 60, 10, 84);
      test_random_traffic(300, 8'd5, 35, 10, 84);
      test_random_traffic(300, 8'd1, 30, 84, 10);
      test_random_traffic(320, 8'd128, 55, 84, 10);
      test_random_traffic(300, 8'd64, 40, 0, 0);
      test_random_traffic(300, 8'd0, 30, 0, 0);

      drain_responses();
      repeat (TailCycles) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses (%0d full, %0d empty, %0d bad position).",
               sent_count, checked_count, full_seen, empty_seen, badpos_seen);
      $display("Limits of 0, 1, 5, 64, 128 and 255 were used; the longest list held %0d entries.",
               peak_length);
      if (fail_count == 0 && due_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
